FILE: design/kmer_seed_pair_matcher_defines.svh
// ----------------------------------------------------------------------------
// kmer_seed_pair_matcher_defines.svh
// Assertion macros shared by the k-mer seed pair matcher.
// ----------------------------------------------------------------------------
`ifndef KMER_SEED_PAIR_MATCHER_DEFINES_SVH
`define KMER_SEED_PAIR_MATCHER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define KSPM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define KSPM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/kspm_pkg.sv
// ----------------------------------------------------------------------------
// kspm_pkg
// Widths, codes, entry type and length helpers of the k-mer seed pair matcher.
// ----------------------------------------------------------------------------
package kspm_pkg;

    localparam int STORE_DEPTH   = 64;
    localparam int MAX_KMER_LEN  = 9;
    localparam int MIN_KMER_LEN  = 4;
    localparam int WINDOW_FACTOR = 10;

    localparam int NT_W   = 3;
    localparam int KMER_W = NT_W * MAX_KMER_LEN;
    localparam int SID_W  = 8;
    localparam int POS_W  = 16;
    localparam int LEN_W  = 4;
    localparam int STAT_W = 2;
    localparam int IDX_W  = $clog2(STORE_DEPTH);
    localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
    localparam int WIN_W  = $clog2(WINDOW_FACTOR * MAX_KMER_LEN + 1);

    localparam logic [LEN_W-1:0] KMER_LEN_RESET = LEN_W'(MIN_KMER_LEN);

    localparam logic FUNC_INSERT = 1'b0;
    localparam logic FUNC_CLEAR  = 1'b1;

    localparam logic [STAT_W-1:0] ST_EDGE  = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_CLEAR = 2'd2;

    typedef struct packed {
        logic [KMER_W-1:0] kmer;
        logic [SID_W-1:0]  sid;
        logic [POS_W-1:0]  pos;
    } t_entry;

    function automatic logic [LEN_W-1:0] kspm_eff_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] eff;
        eff = len;
        if (len < LEN_W'(MIN_KMER_LEN)) begin
            eff = LEN_W'(MIN_KMER_LEN);
        end else if (len > LEN_W'(MAX_KMER_LEN)) begin
            eff = LEN_W'(MAX_KMER_LEN);
        end
        return eff;
    endfunction

    function automatic logic [KMER_W-1:0] kspm_mask(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0]  eff;
        logic [KMER_W-1:0] m;
        eff = kspm_eff_len(len);
        m   = '0;
        for (int n = 0; n < MAX_KMER_LEN; n++) begin
            if (LEN_W'(n) < eff) begin
                m[NT_W*n +: NT_W] = '1;
            end
        end
        return m;
    endfunction

    function automatic logic [WIN_W-1:0] kspm_window(input logic [LEN_W-1:0] len);
        return WIN_W'(WINDOW_FACTOR * int'(kspm_eff_len(len)));
    endfunction

endpackage

FILE: design/kspm_cell.sv
// ----------------------------------------------------------------------------
// kspm_cell
// One store entry of the rotating ring; passes its entry on when shifted.
// ----------------------------------------------------------------------------
module kspm_cell (
    input  logic            i_clk,
    input  logic            i_shift,
    input  kspm_pkg::t_entry i_entry,
    output kspm_pkg::t_entry o_entry
);
    import kspm_pkg::*;

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

FILE: design/kspm_match.sv
// ----------------------------------------------------------------------------
// kspm_match
// Compares the entry at the head of the ring with the query k-mer.
// ----------------------------------------------------------------------------
module kspm_match (
    input  kspm_pkg::t_entry                 i_entry,
    input  kspm_pkg::t_entry                 i_query,
    input  logic [kspm_pkg::KMER_W-1:0]      i_mask,
    input  logic [kspm_pkg::WIN_W-1:0]       i_window,
    output logic                             o_hit
);
    import kspm_pkg::*;

    logic [POS_W-1:0] w_diff;
    logic             w_kmer_eq;
    logic             w_sid_ne;
    logic             w_near;

    assign w_diff    = (i_entry.pos >= i_query.pos) ? (i_entry.pos - i_query.pos)
                                                    : (i_query.pos - i_entry.pos);
    assign w_kmer_eq = ((i_entry.kmer ^ i_query.kmer) & i_mask) == '0;
    assign w_sid_ne  = i_entry.sid != i_query.sid;
    assign w_near    = w_diff <= {{(POS_W-WIN_W){1'b0}}, i_window};
    assign o_hit     = w_kmer_eq && w_sid_ne && w_near;

endmodule

FILE: design/kmer_seed_pair_matcher.sv
// ----------------------------------------------------------------------------
// kmer_seed_pair_matcher
// Insert-and-match store for k-mer seeds built as a rotating ring of cells.
// ----------------------------------------------------------------------------
// The store is a ring of STORE_DEPTH cells, one entry each. An insert rotates
// the ring once round, one cell per cycle while no edge waits on a stalled
// output, past a single comparator at the head; the new k-mer drops into the
// ring as its slot passes, and matches come out in ascending earlier_index
// with last on the final one. The ring holds while an edge waits on a stalled
// output. A clear or a store-full item waits in S_SINGLE until the output
// register is free for its result. Items are taken one at a time; the next
// input transfer can happen while the last result still waits in the output
// register. The user must see that kmer_length is written only when idle;
// the block itself does not enforce this.
module kmer_seed_pair_matcher (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [kspm_pkg::LEN_W-1:0]    i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_func,
    input  logic [kspm_pkg::KMER_W-1:0]   i_kmer,
    input  logic [kspm_pkg::SID_W-1:0]    i_sequence_id,
    input  logic [kspm_pkg::POS_W-1:0]    i_start_position,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [kspm_pkg::STAT_W-1:0]   o_status,
    output logic [kspm_pkg::IDX_W-1:0]    o_earlier_index,
    output logic [kspm_pkg::IDX_W-1:0]    o_new_index,
    output logic                          o_last
);
    import kspm_pkg::*;

    `include "kmer_seed_pair_matcher_defines.svh"

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_DONE   = 4'b0100,
        S_SINGLE = 4'b1000
    } t_state;

    t_state              r_state,  n_state;
    logic [IDX_W-1:0]    r_step,   n_step;
    logic [CNT_W-1:0]    r_count,  n_count;
    logic                r_pend_valid, n_pend_valid;
    logic [IDX_W-1:0]    r_pend_idx,   n_pend_idx;
    t_entry              r_query,  n_query;
    logic [KMER_W-1:0]   r_mask,   n_mask;
    logic [WIN_W-1:0]    r_window, n_window;
    logic [STAT_W-1:0]   r_single_status, n_single_status;
    logic [LEN_W-1:0]    r_kmer_len;
    logic                r_out_valid,   n_out_valid;
    logic [STAT_W-1:0]   r_out_status,  n_out_status;
    logic [IDX_W-1:0]    r_out_earlier, n_out_earlier;
    logic [IDX_W-1:0]    r_out_new,     n_out_new;
    logic                r_out_last,    n_out_last;

    t_entry              w_cell [STORE_DEPTH];
    t_entry              w_tail;
    logic                w_match;
    logic                w_out_free;
    logic                w_accept;
    logic                w_hit;
    logic                w_emit;
    logic                w_shift;
    logic                w_last_step;

    // Ring: cell 0 is the head and holds entry r_step; it wraps into the tail.
    for (genvar g = 0; g < STORE_DEPTH; g++) begin : g_ring
        if (g == STORE_DEPTH - 1) begin : g_tail
            kspm_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_entry (w_tail),
                .o_entry (w_cell[g])
            );
        end else begin : g_body
            kspm_cell u_cell (
                .i_clk   (i_clk),
                .i_shift (w_shift),
                .i_entry (w_cell[g+1]),
                .o_entry (w_cell[g])
            );
        end
    end

    kspm_match u_match (
        .i_entry  (w_cell[0]),
        .i_query  (r_query),
        .i_mask   (r_mask),
        .i_window (r_window),
        .o_hit    (w_match)
    );

    // Drop the new k-mer into its slot as that slot leaves the head.
    assign w_tail      = ({1'b0, r_step} == r_count) ? r_query : w_cell[0];
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_hit       = (r_state == S_SCAN) && ({1'b0, r_step} < r_count) && w_match;
    // A second hit pushes the held edge out; hold the ring if it cannot go.
    assign w_emit      = w_hit && r_pend_valid;
    assign w_shift     = (r_state == S_SCAN) && (!w_emit || w_out_free);
    assign w_last_step = r_step == IDX_W'(STORE_DEPTH - 1);

    always_comb begin
        n_state         = r_state;
        n_step          = r_step;
        n_count         = r_count;
        n_pend_valid    = r_pend_valid;
        n_pend_idx      = r_pend_idx;
        n_query         = r_query;
        n_mask          = r_mask;
        n_window        = r_window;
        n_single_status = r_single_status;
        n_out_valid     = r_out_valid && i_out_stall;
        n_out_status    = r_out_status;
        n_out_earlier   = r_out_earlier;
        n_out_new       = r_out_new;
        n_out_last      = r_out_last;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_query      = '{kmer: i_kmer, sid: i_sequence_id, pos: i_start_position};
                    n_mask       = kspm_mask(r_kmer_len);
                    n_window     = kspm_window(r_kmer_len);
                    n_step       = '0;
                    n_pend_valid = 1'b0;
                    if (i_func == FUNC_CLEAR) begin
                        n_count         = '0;
                        n_single_status = ST_CLEAR;
                        n_state         = S_SINGLE;
                    end else if (r_count == CNT_W'(STORE_DEPTH)) begin
                        n_single_status = ST_FULL;
                        n_state         = S_SINGLE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (w_shift) begin
                    n_step = r_step + 1'b1;
                    if (w_emit) begin
                        n_out_valid   = 1'b1;
                        n_out_status  = ST_EDGE;
                        n_out_earlier = r_pend_idx;
                        n_out_new     = r_count[IDX_W-1:0];
                        n_out_last    = 1'b0;
                    end
                    if (w_hit) begin
                        n_pend_valid = 1'b1;
                        n_pend_idx   = r_step;
                    end
                    if (w_last_step) begin
                        n_count = r_count + 1'b1;
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = ST_EDGE;
                    n_out_earlier = r_pend_idx;
                    n_out_new     = IDX_W'(r_count - 1'b1);
                    n_out_last    = 1'b1;
                    n_pend_valid  = 1'b0;
                    n_state       = S_IDLE;
                end
            end
            S_SINGLE: begin
                if (w_out_free) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_single_status;
                    n_out_earlier = '0;
                    n_out_new     = '0;
                    n_out_last    = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_step       <= '0;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_kmer_len   <= KMER_LEN_RESET;
        end else begin
            r_state      <= n_state;
            r_step       <= n_step;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            if (i_cfg_we) begin
                r_kmer_len <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx      <= n_pend_idx;
        r_query         <= n_query;
        r_mask          <= n_mask;
        r_window        <= n_window;
        r_single_status <= n_single_status;
        r_out_status    <= n_out_status;
        r_out_earlier   <= n_out_earlier;
        r_out_new       <= n_out_new;
        r_out_last      <= n_out_last;
    end

    assign o_in_stall      = r_state != S_IDLE;
    assign o_out_valid     = r_out_valid;
    assign o_status        = r_out_status;
    assign o_earlier_index = r_out_earlier;
    assign o_new_index     = r_out_new;
    assign o_last          = r_out_last;

    `KSPM_ASSERT_NEXT(a_count_step, i_clk, i_rst_n,
        (r_state == S_SCAN) && w_shift && w_last_step,
        (r_count == $past(r_count) + 1'b1) && (r_state == S_DONE),
        "store count did not advance at the end of the ring rotation")
    `KSPM_ASSERT_NOW(a_edge_order, i_clk, i_rst_n,
        r_out_valid && (r_out_status == ST_EDGE),
        r_out_earlier < r_out_new,
        "edge names an earlier index that is not below the new index")
    `KSPM_ASSERT_NOW(a_pend_scope, i_clk, i_rst_n,
        r_pend_valid,
        (r_state == S_SCAN) || (r_state == S_DONE),
        "held edge outside an insert")

endmodule
